// File: hdl/ttss_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types, codes and constants of the three-track step sequencer.
package ttss_pkg;

  localparam int NUM_TRACKS = 3;
  localparam int TRK_W      = 2;
  localparam int MODE_W     = 2;
  localparam int STEP_W     = 16;
  localparam int SR_W       = 18;
  localparam int TEMPO_W    = 24;
  localparam int LOOP_W     = 24;
  localparam int FRAME_W    = 40;
  localparam int POS_W      = 50;
  localparam int SUM_W      = 37;
  localparam int Q_FRAC     = 16;
  localparam int PROD_W     = SUM_W + TEMPO_W;
  localparam int DUE_W      = PROD_W - Q_FRAC;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_CNT_W  = $clog2(POS_W + 1);

  typedef logic [TRK_W-1:0]   trk_t;
  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [SR_W-1:0]    sr_t;
  typedef logic [TEMPO_W-1:0] tempo_t;
  typedef logic [LOOP_W-1:0]  loop_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [DUE_W-1:0]   due_t;

  localparam sr_t    SR_RESET    = 18'd48000;
  localparam tempo_t TEMPO_RESET = 24'd65536;
  localparam sum_t   BAR_MS      = 37'd4000;
  localparam pos_t   MS_PER_S    = 50'd1000;
  localparam trk_t   TRK_LIMIT   = 2'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_APPEND = 2'd2,
    MODE_REWIND = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE = 8'd0,
    CFG_TEMPO_SCALE = 8'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD,
    ST_LOAD,
    ST_MUL,
    ST_WAITDIV,
    ST_CMP,
    ST_DONE
  } state_e;

endpackage

// File: hdl/ttss_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module ttss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ttss_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the millisecond position.
module ttss_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ttss_pkg::pos_t  dividend_i,
  input  ttss_pkg::sr_t   divisor_i,
  output logic            busy_o,
  output ttss_pkg::pos_t  quotient_o
);

  localparam int PW = ttss_pkg::POS_W;
  localparam int SW = ttss_pkg::SR_W;
  localparam int CW = ttss_pkg::DIV_CNT_W;

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] dvd_q, dvd_d;
  logic [SW-1:0] rem_q, rem_d;
  logic [SW-1:0] dsr_q, dsr_d;
  logic [SW:0]   trial;
  logic [SW:0]   diff;
  logic          ge;

  always_comb begin
    trial  = {rem_q, dvd_q[PW-1]};
    diff   = trial - {1'b0, dsr_q};
    ge     = (trial >= {1'b0, dsr_q});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(PW);
      dvd_d  = dividend_i;
      rem_d  = '0;
      // A zero rate divides by one.
      dsr_d  = (divisor_i == '0) ? SW'(1) : divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[SW-1:0] : trial[SW-1:0];
      dvd_d  = {dvd_q[PW-2:0], ge};
      cnt_d  = cnt_q - CW'(1);
      busy_d = (cnt_q != CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = dvd_q;

endmodule

// File: hdl/ttss_due.sv
`timescale 1ns / 1ps
// Two-stage pipeline for the scaled due time of one track step.
module ttss_due (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ttss_pkg::step_t   step_i,
  input  ttss_pkg::loop_t   loop_i,
  input  ttss_pkg::tempo_t  tempo_i,
  output logic              valid_o,
  output ttss_pkg::due_t    due_o
);

  localparam int LO_W    = 19;
  localparam int HI_W    = ttss_pkg::SUM_W - LO_W;
  localparam int PP_LO_W = LO_W + ttss_pkg::TEMPO_W;
  localparam int PP_HI_W = HI_W + ttss_pkg::TEMPO_W;
  localparam int PROD_W  = ttss_pkg::PROD_W;

  logic               v1_q, v2_q;
  ttss_pkg::sum_t     sum_q;
  ttss_pkg::tempo_t   tempo_q;
  logic [PP_LO_W-1:0] pp_lo_q;
  logic [PP_HI_W-1:0] pp_hi_q;
  logic [PROD_W-1:0]  prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // The bar offset is a constant product; the tempo product is split in two halves.
  always_ff @(posedge clk_i) begin
    sum_q   <= ttss_pkg::sum_t'(step_i) + ttss_pkg::sum_t'(loop_i) * ttss_pkg::BAR_MS;
    tempo_q <= tempo_i;
    pp_lo_q <= PP_LO_W'(sum_q[LO_W-1:0]) * PP_LO_W'(tempo_q);
    pp_hi_q <= PP_HI_W'(sum_q[ttss_pkg::SUM_W-1:LO_W]) * PP_HI_W'(tempo_q);
  end

  assign prod    = (PROD_W'(pp_hi_q) << LO_W) + PROD_W'(pp_lo_q);
  assign due_o   = prod[PROD_W-1:ttss_pkg::Q_FRAC];
  assign valid_o = v2_q;

endmodule

// File: hdl/three_track_step_sequencer_unit.sv
`timescale 1ns / 1ps
// Top level of the three-track step sequencer: control, track state and step memory.
//
//  Channel  Direction  Signals                      Contents
//  s_axis   in         tvalid tready tdata tuser    tdata: step_time; tuser: mode, track
//  m_axis   out        tvalid tready tdata          tdata: fire_click, fire_tom, fire_snare
//  cfg      in         cfg_valid/ready index data   0 sample_rate, 1 tempo_scale
//
// A frame tick starts the restoring divider that turns the frame count into milliseconds;
// the three step reads and due products run alongside it, and the wait, compare and
// completion states follow. Clear, append and rewind pass through the execute and
// completion states. The next input transfer can follow once the block is idle again,
// while the result still waits on m_axis_tready.
// Reset empties the patterns, zeroes the counters and sets 48000 and 1.0 (Q8.16).
module three_track_step_sequencer_unit #(
  parameter int MAX_STEPS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] step_time
  input  logic [3:0]  s_axis_tuser,   // [1:0] mode, [3:2] track
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] fire_click, [1] fire_tom, [2] fire_snare
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int NT     = ttss_pkg::NUM_TRACKS;
  localparam int IDX_W  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int LEN_W  = $clog2(MAX_STEPS + 1);
  localparam int DEPTH  = NT * MAX_STEPS;
  localparam int ADDR_W = $clog2(DEPTH);

  ttss_pkg::state_e state_q, state_d;
  ttss_pkg::mode_e  mode_q, mode_d;
  ttss_pkg::trk_t   track_q, track_d;
  ttss_pkg::step_t  step_q, step_d;
  ttss_pkg::trk_t   trk_q, trk_d;
  ttss_pkg::sr_t    sr_q;
  ttss_pkg::tempo_t tempo_q;
  ttss_pkg::frame_t frame_q, frame_d;

  logic [LEN_W-1:0] len_q  [NT];
  logic [LEN_W-1:0] len_d  [NT];
  logic [IDX_W-1:0] idx_q  [NT];
  logic [IDX_W-1:0] idx_d  [NT];
  ttss_pkg::loop_t  loop_q [NT];
  ttss_pkg::loop_t  loop_d [NT];
  ttss_pkg::due_t   due_q  [NT];
  ttss_pkg::due_t   due_d  [NT];

  logic [NT-1:0] res_q, res_d;
  logic          out_valid_q, out_valid_d;
  logic [NT-1:0] out_q, out_d;

  // Selected track for memory addressing and state lookup.
  ttss_pkg::trk_t   sel_trk;
  logic             sel_ok;
  logic [LEN_W-1:0] sel_len;
  logic [IDX_W-1:0] sel_idx;
  logic [IDX_W-1:0] sel_eff;
  ttss_pkg::loop_t  sel_loop;
  logic [ADDR_W-1:0] base;

  logic              accept;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  ttss_pkg::step_t   ram_rdata;

  logic             div_start;
  logic             div_busy;
  ttss_pkg::pos_t   pos;
  ttss_pkg::pos_t   dividend;

  logic             due_start;
  logic             due_valid;
  ttss_pkg::due_t   due_val;

  // Per-track firing decision, from the latched due times and the finished position.
  logic [IDX_W-1:0] eff    [NT];
  logic [LEN_W-1:0] nxt    [NT];
  logic [NT-1:0]    fire;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ttss_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8 - NT){1'b0}}, out_q};

  assign dividend  = ttss_pkg::pos_t'(frame_q) * ttss_pkg::MS_PER_S;
  assign div_start = accept && (s_axis_tuser[1:0] == ttss_pkg::MODE_TICK);
  assign due_start = (state_q == ttss_pkg::ST_LOAD);

  always_comb begin
    sel_trk  = (state_q == ttss_pkg::ST_EXEC) ? track_q : trk_q;
    sel_ok   = (sel_trk < ttss_pkg::TRK_LIMIT);
    sel_len  = sel_ok ? len_q[sel_trk]  : '0;
    sel_idx  = sel_ok ? idx_q[sel_trk]  : '0;
    sel_loop = sel_ok ? loop_q[sel_trk] : '0;
    sel_eff  = (LEN_W'(sel_idx) >= sel_len) ? '0 : sel_idx;
    base     = ADDR_W'(sel_trk) * ADDR_W'(MAX_STEPS);
    ram_raddr = base + ADDR_W'(sel_eff);
    ram_waddr = base + ADDR_W'(sel_len);
    ram_we    = (state_q == ttss_pkg::ST_EXEC) && (mode_q == ttss_pkg::MODE_APPEND) &&
                sel_ok && (sel_len < LEN_W'(MAX_STEPS));
  end

  always_comb begin
    for (int t = 0; t < NT; t++) begin
      eff[t]  = (LEN_W'(idx_q[t]) >= len_q[t]) ? '0 : idx_q[t];
      nxt[t]  = LEN_W'(eff[t]) + LEN_W'(1);
      fire[t] = (len_q[t] != '0) && (pos >= ttss_pkg::pos_t'(due_q[t]));
    end
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    track_d     = track_q;
    step_d      = step_q;
    trk_d       = trk_q;
    frame_d     = frame_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    len_d       = len_q;
    idx_d       = idx_q;
    loop_d      = loop_q;
    due_d       = due_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ttss_pkg::ST_IDLE: begin
        if (accept) begin
          mode_d  = ttss_pkg::mode_e'(s_axis_tuser[1:0]);
          track_d = s_axis_tuser[3:2];
          step_d  = s_axis_tdata;
          trk_d   = '0;
          state_d = (s_axis_tuser[1:0] == ttss_pkg::MODE_TICK) ? ttss_pkg::ST_RD
                                                               : ttss_pkg::ST_EXEC;
        end
      end
      ttss_pkg::ST_EXEC: begin
        res_d = '0;
        case (mode_q)
          ttss_pkg::MODE_CLEAR: begin
            if (sel_ok) begin
              len_d[sel_trk] = '0;
              idx_d[sel_trk] = '0;
            end
          end
          ttss_pkg::MODE_APPEND: begin
            if (ram_we) begin
              len_d[sel_trk] = sel_len + LEN_W'(1);
            end
          end
          ttss_pkg::MODE_REWIND: begin
            frame_d = '0;
            for (int t = 0; t < NT; t++) begin
              loop_d[t] = '0;
              idx_d[t]  = '0;
            end
          end
          default: ;
        endcase
        state_d = ttss_pkg::ST_DONE;
      end
      ttss_pkg::ST_RD: begin
        state_d = ttss_pkg::ST_LOAD;
      end
      ttss_pkg::ST_LOAD: begin
        state_d = ttss_pkg::ST_MUL;
      end
      ttss_pkg::ST_MUL: begin
        if (due_valid) begin
          due_d[trk_q] = due_val;
          if (trk_q == ttss_pkg::trk_t'(NT - 1)) begin
            state_d = ttss_pkg::ST_WAITDIV;
          end else begin
            trk_d   = trk_q + ttss_pkg::trk_t'(1);
            state_d = ttss_pkg::ST_RD;
          end
        end
      end
      ttss_pkg::ST_WAITDIV: begin
        if (!div_busy) begin
          state_d = ttss_pkg::ST_CMP;
        end
      end
      ttss_pkg::ST_CMP: begin
        res_d = fire;
        for (int t = 0; t < NT; t++) begin
          if (fire[t]) begin
            if (nxt[t] >= len_q[t]) begin
              idx_d[t]  = '0;
              loop_d[t] = loop_q[t] + ttss_pkg::loop_t'(1);
            end else begin
              idx_d[t] = nxt[t][IDX_W-1:0];
            end
          end
        end
        frame_d = frame_q + ttss_pkg::frame_t'(1);
        state_d = ttss_pkg::ST_DONE;
      end
      ttss_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ttss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ttss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttss_pkg::ST_IDLE;
      trk_q       <= '0;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
      sr_q        <= ttss_pkg::SR_RESET;
      tempo_q     <= ttss_pkg::TEMPO_RESET;
      for (int t = 0; t < NT; t++) begin
        len_q[t]  <= '0;
        idx_q[t]  <= '0;
        loop_q[t] <= '0;
      end
    end else begin
      state_q     <= state_d;
      trk_q       <= trk_d;
      frame_q     <= frame_d;
      out_valid_q <= out_valid_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      loop_q      <= loop_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == ttss_pkg::CFG_SAMPLE_RATE) begin
          sr_q <= cfg_data_i[ttss_pkg::SR_W-1:0];
        end else if (cfg_index_i == ttss_pkg::CFG_TEMPO_SCALE) begin
          tempo_q <= cfg_data_i[ttss_pkg::TEMPO_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    track_q <= track_d;
    step_q  <= step_d;
    res_q   <= res_d;
    out_q   <= out_d;
    due_q   <= due_d;
  end

  ttss_ram #(
    .WIDTH (ttss_pkg::STEP_W),
    .DEPTH (DEPTH)
  ) u_step_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (step_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ttss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (sr_q),
    .busy_o     (div_busy),
    .quotient_o (pos)
  );

  ttss_due u_due (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (due_start),
    .step_i  (ram_rdata),
    .loop_i  (sel_loop),
    .tempo_i (tempo_q),
    .valid_o (due_valid),
    .due_o   (due_val)
  );

  // The divider must have finished before the block can take another item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ttss_pkg::ST_IDLE) |-> !div_busy)
    else $error("divider still busy while idle");

  // A result appears only on leaving the completion state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ttss_pkg::ST_DONE))
    else $error("result presented outside completion");

  // Pattern lengths stay within the step memory slice of each track.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q[0] <= LEN_W'(MAX_STEPS)) && (len_q[1] <= LEN_W'(MAX_STEPS)) &&
    (len_q[2] <= LEN_W'(MAX_STEPS)))
    else $error("pattern length beyond capacity");

  // A read index always points inside a non-empty pattern.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((len_q[0] == '0) || (LEN_W'(idx_q[0]) < len_q[0])) &&
    ((len_q[1] == '0) || (LEN_W'(idx_q[1]) < len_q[1])) &&
    ((len_q[2] == '0) || (LEN_W'(idx_q[2]) < len_q[2])))
    else $error("read index outside pattern");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the three-track step sequencer: stimulus, prediction, scoreboard.
module testbench;

  // The block is built with its default pattern depth, and the predictor follows it.
  localparam int STEPS_PER_TRACK = 32;
  // A tick is the slowest item; this settle time outlasts its result.
  localparam int SETTLE_CYCLES   = 64;
  // Random items that follow the pattern programming of each phase.
  localparam int PHASE_ITEMS     = 45;
  localparam int N_DIRECTED      = 23;
  // An index that selects no register; a write to it must change nothing.
  localparam logic [ttss_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd2;

  typedef logic [ttss_pkg::NUM_TRACKS-1:0] fire_set_t;

  // One row of the directed table. Where typed is set, fires holds the result that the row
  // must give; otherwise the result comes from the predictor.
  typedef struct packed {
    ttss_pkg::mode_e mode;
    ttss_pkg::trk_t  trk;
    ttss_pkg::step_t st;
    logic            typed;
    fire_set_t       fires;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] step_time
  logic [3:0]  s_axis_tuser;   // [1:0] mode, [3:2] track
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [0] fire_click, [1] fire_tom, [2] fire_snare
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  // Predictor state: a private copy of the patterns, counters and registers.
  ttss_pkg::step_t  pat_steps [ttss_pkg::NUM_TRACKS][STEPS_PER_TRACK];
  int unsigned      pat_len   [ttss_pkg::NUM_TRACKS];
  int unsigned      read_pos  [ttss_pkg::NUM_TRACKS];
  ttss_pkg::loop_t  loops     [ttss_pkg::NUM_TRACKS];
  ttss_pkg::frame_t frames;
  ttss_pkg::sr_t    rate;
  ttss_pkg::tempo_t tempo;

  // Scoreboard: expected fire sets in order of acceptance, and run statistics.
  fire_set_t   expected_fires [$];
  int          n_errors;
  int          n_sent;
  int          n_checked;
  int          n_cfg_writes;
  int          fire_hits [ttss_pkg::NUM_TRACKS];
  string       fire_names [ttss_pkg::NUM_TRACKS] = '{"fire_click", "fire_tom", "fire_snare"};

  // Idling control. A calm side never waits; rx_hold counts the stall cycles still owed.
  bit          tx_calm;
  bit          rx_calm;
  int          rx_hold;

  stim_row_t   directed_rows [N_DIRECTED];

  three_track_step_sequencer_unit #(
    .MAX_STEPS(STEPS_PER_TRACK)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Sequencer predictor. It applies one accepted item to the private state and returns the
  // set of tracks that fire. Only a tick can fire; the other modes edit patterns or counters.
  function automatic fire_set_t advance_sequencer(ttss_pkg::mode_e m, ttss_pkg::trk_t trk,
                                                  ttss_pkg::step_t st);
    fire_set_t   fires;
    logic [63:0] divisor;
    logic [63:0] pos_ms;
    logic [63:0] due_ms;
    int          t;
    fires = '0;
    case (m)
      ttss_pkg::MODE_TICK: begin
        // A zero sample rate is taken as a divisor of one.
        divisor = (rate == '0) ? 64'd1 : 64'(rate);
        pos_ms  = (64'(frames) * 64'(ttss_pkg::MS_PER_S)) / divisor;
        for (t = 0; t < ttss_pkg::NUM_TRACKS; t++) begin
          if (pat_len[t] != 0) begin
            due_ms = ((64'(pat_steps[t][read_pos[t]]) +
                       64'(loops[t]) * 64'(ttss_pkg::BAR_MS)) * 64'(tempo)) >> ttss_pkg::Q_FRAC;
            if (pos_ms >= due_ms) begin
              fires[t] = 1'b1;
              if (read_pos[t] + 1 >= pat_len[t]) begin
                read_pos[t] = 0;
                loops[t]    = loops[t] + 1'b1;
              end else begin
                read_pos[t] = read_pos[t] + 1;
              end
            end
          end
        end
        frames = frames + 1'b1;
      end
      ttss_pkg::MODE_CLEAR: begin
        // Clearing keeps the loop count; track 3 selects nothing.
        if (trk < ttss_pkg::TRK_LIMIT) begin
          pat_len[trk]  = 0;
          read_pos[trk] = 0;
        end
      end
      ttss_pkg::MODE_APPEND: begin
        // An append to a full pattern is dropped.
        if (trk < ttss_pkg::TRK_LIMIT && pat_len[trk] < STEPS_PER_TRACK) begin
          pat_steps[trk][pat_len[trk]] = st;
          pat_len[trk] = pat_len[trk] + 1;
        end
      end
      default: begin
        frames = '0;
        for (t = 0; t < ttss_pkg::NUM_TRACKS; t++) begin
          loops[t]    = '0;
          read_pos[t] = 0;
        end
      end
    endcase
    return fires;
  endfunction

  // Step times are mostly small, so that positions reach them within a phase, with the odd
  // full-range value to exercise every bit of the field.
  function automatic ttss_pkg::step_t draw_step(int unsigned step_max);
    if ($urandom_range(0, 4) == 0) begin
      return ttss_pkg::step_t'($urandom);
    end
    return ttss_pkg::step_t'($urandom_range(0, step_max));
  endfunction

  // Offers one item on s_axis after a random gap and waits for its transfer. The expected
  // fire set is recorded at the very edge at which the item is taken.
  task automatic send_item(ttss_pkg::mode_e m, ttss_pkg::trk_t trk, ttss_pkg::step_t st,
                           logic typed, fire_set_t typed_fires);
    int        gap;
    fire_set_t predicted;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {trk, m};
    s_axis_tdata  <= st;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = advance_sequencer(m, trk, st);
    expected_fires.insert(expected_fires.size(), typed ? typed_fires : predicted);
    n_sent++;
  endtask

  // Stops offering items and waits until every expected result has been through the
  // scoreboard, then lets the block settle.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_fires.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One transfer on the configuration channel. The predictor keeps only the bits that the
  // register holds.
  task automatic write_register(logic [ttss_pkg::CFG_IDX_W-1:0] idx,
                                logic [ttss_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == ttss_pkg::CFG_SAMPLE_RATE) begin
      rate = value[ttss_pkg::SR_W-1:0];
    end else if (idx == ttss_pkg::CFG_TEMPO_SCALE) begin
      tempo = value[ttss_pkg::TEMPO_W-1:0];
    end
    n_cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One phase of random stimulus under a fresh register setting. Each track is first given
  // a short pattern, then mostly ticks follow, mixed with appends, clears and rewinds. A
  // phase may also fill one track past its depth, and may stop once half-way until the
  // block has delivered every result.
  task automatic run_phase(logic [31:0] rate_word, logic [31:0] tempo_word,
                           int unsigned step_max, bit calm, int fill_trk, bit pause_mid);
    int          t;
    int          k;
    int          n_steps;
    int unsigned pick;
    wait_drained();
    write_register(ttss_pkg::CFG_SAMPLE_RATE, rate_word);
    write_register(ttss_pkg::CFG_TEMPO_SCALE, tempo_word);
    tx_calm = calm;
    rx_calm = calm;
    for (t = 0; t < ttss_pkg::NUM_TRACKS; t++) begin
      send_item(ttss_pkg::MODE_CLEAR, ttss_pkg::trk_t'(t), ttss_pkg::step_t'($urandom),
                1'b0, '0);
      n_steps = $urandom_range(1, 4);
      for (k = 0; k < n_steps; k++) begin
        send_item(ttss_pkg::MODE_APPEND, ttss_pkg::trk_t'(t), draw_step(step_max), 1'b0, '0);
      end
    end
    send_item(ttss_pkg::MODE_REWIND, ttss_pkg::trk_t'($urandom), ttss_pkg::step_t'($urandom),
              1'b0, '0);
    if (fill_trk >= 0) begin
      // Two appends more than the pattern holds, so the last two are dropped.
      send_item(ttss_pkg::MODE_CLEAR, ttss_pkg::trk_t'(fill_trk), '0, 1'b0, '0);
      for (k = 0; k < STEPS_PER_TRACK + 2; k++) begin
        send_item(ttss_pkg::MODE_APPEND, ttss_pkg::trk_t'(fill_trk), draw_step(step_max),
                  1'b0, '0);
      end
    end
    for (k = 0; k < PHASE_ITEMS; k++) begin
      if (pause_mid && k == PHASE_ITEMS / 2) begin
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        send_item(ttss_pkg::MODE_TICK, ttss_pkg::trk_t'($urandom),
                  ttss_pkg::step_t'($urandom), 1'b0, '0);
      end else if (pick < 86) begin
        send_item(ttss_pkg::MODE_APPEND, ttss_pkg::trk_t'($urandom), draw_step(step_max),
                  1'b0, '0);
      end else if (pick < 93) begin
        send_item(ttss_pkg::MODE_CLEAR, ttss_pkg::trk_t'($urandom),
                  ttss_pkg::step_t'($urandom), 1'b0, '0);
      end else begin
        send_item(ttss_pkg::MODE_REWIND, ttss_pkg::trk_t'($urandom),
                  ttss_pkg::step_t'($urandom), 1'b0, '0);
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // Result side. tready is changed only at falling edges: it drops for the stall drawn at
  // the last transfer and otherwise stays high.
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Scoreboard. Every result transfer is matched against the oldest expectation, field by
  // field; the padding bits above the three fire flags must be zero.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_fires.size() == 0) begin
        $error("Result transfer with no expectation waiting: tdata %02h", m_axis_tdata);
        n_errors++;
      end else begin
        for (int k = 0; k < ttss_pkg::NUM_TRACKS; k++) begin
          if (m_axis_tdata[k] !== expected_fires[0][k]) begin
            $error("%s: expected %0b, got %0b", fire_names[k], expected_fires[0][k],
                   m_axis_tdata[k]);
            n_errors++;
          end
          if (expected_fires[0][k]) fire_hits[k]++;
        end
        if (m_axis_tdata[7:ttss_pkg::NUM_TRACKS] !== '0) begin
          $error("tdata padding: expected 0, got %0h", m_axis_tdata[7:ttss_pkg::NUM_TRACKS]);
          n_errors++;
        end
        void'(expected_fires.pop_front());
        n_checked++;
      end
      rx_hold = rx_calm ? 0 : $urandom_range(0, 5);
    end
  end

  // Watchdog: the slowest correct run takes well under a millisecond of simulated time.
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    // All inputs are known from time zero, with reset asserted.
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    rx_hold       = 0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    n_errors      = 0;
    n_sent        = 0;
    n_checked     = 0;
    n_cfg_writes  = 0;
    fire_hits     = '{0, 0, 0};

    // The predictor starts from the reset state of the block.
    pat_len  = '{0, 0, 0};
    read_pos = '{0, 0, 0};
    loops    = '{'0, '0, '0};
    frames   = '0;
    rate     = ttss_pkg::SR_RESET;
    tempo    = ttss_pkg::TEMPO_RESET;

    // Directed part, run under the reset register values (48000 frames per second, tempo 1.0).
    // Non-tick modes always give an empty fire set, as do ticks before any pattern exists.
    directed_rows = '{
      '{ttss_pkg::MODE_TICK,   2'd0, 16'h0000, 1'b1, 3'b000},  // no patterns yet
      '{ttss_pkg::MODE_TICK,   2'd3, 16'hFFFF, 1'b1, 3'b000},  // unused fields all ones
      '{ttss_pkg::MODE_APPEND, 2'd0, 16'h0000, 1'b1, 3'b000},
      '{ttss_pkg::MODE_APPEND, 2'd1, 16'hFFFF, 1'b1, 3'b000},  // latest possible hit time
      '{ttss_pkg::MODE_APPEND, 2'd2, 16'h0000, 1'b1, 3'b000},
      '{ttss_pkg::MODE_APPEND, 2'd3, 16'h0000, 1'b1, 3'b000},  // no such track
      '{ttss_pkg::MODE_TICK,   2'd0, 16'h0000, 1'b0, 3'b000},
      '{ttss_pkg::MODE_TICK,   2'd0, 16'h0000, 1'b0, 3'b000},
      '{ttss_pkg::MODE_APPEND, 2'd2, 16'h0001, 1'b1, 3'b000},
      '{ttss_pkg::MODE_CLEAR,  2'd2, 16'hFFFF, 1'b1, 3'b000},  // clear keeps the loop count
      '{ttss_pkg::MODE_APPEND, 2'd2, 16'h0000, 1'b1, 3'b000},
      '{ttss_pkg::MODE_TICK,   2'd1, 16'h5A5A, 1'b0, 3'b000},
      '{ttss_pkg::MODE_REWIND, 2'd3, 16'hFFFF, 1'b1, 3'b000},
      '{ttss_pkg::MODE_TICK,   2'd2, 16'hA5A5, 1'b0, 3'b000},
      '{ttss_pkg::MODE_CLEAR,  2'd3, 16'h0000, 1'b1, 3'b000},  // no such track
      '{ttss_pkg::MODE_CLEAR,  2'd0, 16'h0000, 1'b1, 3'b000},
      '{ttss_pkg::MODE_TICK,   2'd0, 16'h0000, 1'b0, 3'b000},
      '{ttss_pkg::MODE_APPEND, 2'd1, 16'h0000, 1'b1, 3'b000},
      '{ttss_pkg::MODE_REWIND, 2'd0, 16'h0000, 1'b1, 3'b000},
      '{ttss_pkg::MODE_TICK,   2'd0, 16'h0000, 1'b0, 3'b000},
      '{ttss_pkg::MODE_TICK,   2'd0, 16'h0000, 1'b0, 3'b000},
      '{ttss_pkg::MODE_APPEND, 2'd0, 16'h8000, 1'b1, 3'b000},
      '{ttss_pkg::MODE_TICK,   2'd0, 16'h0000, 1'b0, 3'b000}
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < N_DIRECTED; r++) begin
      send_item(directed_rows[r].mode, directed_rows[r].trk, directed_rows[r].st,
                directed_rows[r].typed, directed_rows[r].fires);
    end

    // A write to an index with no register behind it must leave the setting alone.
    wait_drained();
    write_register(CFG_UNUSED_IDX, '1);

    // Phases walk the register extremes. The first repeats the reset values with the
    // unused upper data bits set; the zero rate turns the position into frames times 1000.
    run_phase(32'hFFFC_0000 | 32'd48000, 32'hFF01_0000, 2, 1'b0, -1, 1'b1);
    run_phase(32'd8000, 32'd1, 20, 1'b1, 1, 1'b0);
    run_phase(32'd0, 32'h00FF_FFFF, 300, 1'b0, -1, 1'b0);
    run_phase(32'd192000, 32'd32768, 3, 1'b0, -1, 1'b0);
    run_phase(32'h0003_FFFF, $urandom_range(1, 24'hFF_FFFF), 2, 1'b0, -1, 1'b0);
    run_phase($urandom_range(8000, 192000), $urandom_range(1, 131072), 10, 1'b0, -1, 1'b0);

    wait_drained();
    if (expected_fires.size() != 0) begin
      $error("%0d expected results never arrived", expected_fires.size());
      n_errors++;
    end

    $display("Run covered %0d items in six register settings (%0d register writes), %0d results.",
             n_sent, n_cfg_writes, n_checked);
    $display("Tracks fired: click %0d, tom %0d, snare %0d times.",
             fire_hits[0], fire_hits[1], fire_hits[2]);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
